// File: rtl/fdtp_pkg.sv
// Package for the flattened device tree structure parser.
// Holds token values, walk phases, event kinds and the state and event structs.
// Used by fdtp_step, fdt_struct_token_parser_top and the testbench; depends on nothing else.
`default_nettype none

package fdtp_pkg;

    // Big-endian token values of the structure block.
    localparam logic [31:0] TOK_BEGIN_NODE = 32'h0000_0001;
    localparam logic [31:0] TOK_END_NODE   = 32'h0000_0002;
    localparam logic [31:0] TOK_PROP       = 32'h0000_0003;
    localparam logic [31:0] TOK_NOP        = 32'h0000_0004;
    localparam logic [31:0] TOK_END        = 32'h0000_0009;

    // Configuration register indexes.
    localparam logic CFG_SIZE_LIMIT   = 1'b0;
    localparam logic CFG_STRINGS_BASE = 1'b1;

    localparam logic [31:0] SIZE_LIMIT_RESET   = 32'hFFFF_FFFF;
    localparam logic [31:0] STRINGS_BASE_RESET = 32'h0000_0000;

    // Walk phase, one-hot.
    typedef enum logic [4:0] {
        PH_TOKEN = 5'b00001,
        PH_NAME  = 5'b00010,
        PH_PLEN  = 5'b00100,
        PH_POFF  = 5'b01000,
        PH_SKIP  = 5'b10000
    } t_phase;

    // Event kinds reported on the result channel.
    typedef enum logic [2:0] {
        EV_BEGIN   = 3'd0,
        EV_ENDNODE = 3'd1,
        EV_NOP     = 3'd2,
        EV_PROP    = 3'd3,
        EV_END     = 3'd4,
        EV_BAD     = 3'd5,
        EV_OVERRUN = 3'd6
    } t_event_kind;

    // Walker state apart from the byte position.
    typedef struct packed {
        t_phase      phase;
        logic [31:0] word_shift;
        logic [1:0]  byte_index;
        logic [31:0] skip_count;
        logic [31:0] size_latch;
        logic        finished;
    } t_walk_state;

    // One result event.
    typedef struct packed {
        t_event_kind kind;
        logic [31:0] item_offset;
        logic [31:0] prop_size;
        logic [31:0] name_address;
    } t_event;

endpackage

`default_nettype wire

// File: rtl/fdtp_byte_if.sv
// Request channel carrying one structure-block byte per request.
// Depends on nothing else.
`default_nettype none

interface fdtp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/fdtp_event_if.sv
// Result channel carrying one parser event per request.
// Depends on nothing else.
`default_nettype none

interface fdtp_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [31:0] item_offset;
    logic [31:0] prop_size;
    logic [31:0] name_address;

    modport source (output valid, output event_kind, output item_offset,
                    output prop_size, output name_address, input ready);
    modport sink   (input valid, input event_kind, input item_offset,
                    input prop_size, input name_address, output ready);
endinterface

`default_nettype wire

// File: rtl/fdtp_step.sv
// Per-byte next-state and event logic of the structure walker.
// Depends on fdtp_pkg; purely combinational, registered by the top level.
`default_nettype none

module fdtp_step #(
    parameter int OFFSET_BITS = 32
) (
    input  fdtp_pkg::t_walk_state     i_state,
    input  wire [OFFSET_BITS-1:0]     i_position,
    input  wire [7:0]                 i_data_byte,
    input  wire [31:0]                i_size_limit,
    input  wire [31:0]                i_strings_base,
    output fdtp_pkg::t_walk_state     o_state,
    output logic [OFFSET_BITS-1:0]    o_position,
    output logic                      o_event_valid,
    output fdtp_pkg::t_event          o_event
);
    import fdtp_pkg::*;

    localparam int EXT_W = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

    logic [OFFSET_BITS-1:0] pos_next;
    logic [EXT_W-1:0]       pos_next_ext;
    logic [31:0]            offset_next;
    logic                   over_limit;
    logic [31:0]            word_new;
    logic                   word_done;
    logic [31:0]            prop_addr;
    logic [32:0]            padded_sum;
    logic [31:0]            padded;

    // Position arithmetic and the byte budget check.
    assign pos_next     = i_position + OFFSET_BITS'(1);
    assign pos_next_ext = EXT_W'(pos_next);
    assign offset_next  = pos_next_ext[31:0];
    assign over_limit   = EXT_W'(i_position) >= EXT_W'(i_size_limit);

    // Word assembly and the property arithmetic.
    assign word_new   = {i_state.word_shift[23:0], i_data_byte};
    assign word_done  = (i_state.byte_index == 2'd3);
    assign prop_addr  = i_strings_base + word_new;
    assign padded_sum = {1'b0, i_state.size_latch} + 33'd3;
    assign padded     = padded_sum[32] ? 32'hFFFF_FFFF : {padded_sum[31:2], 2'b00};

    always_comb begin
        o_state       = i_state;
        o_position    = i_position;
        o_event_valid = 1'b0;
        o_event       = '{kind: EV_BEGIN, item_offset: 32'd0, prop_size: 32'd0,
                          name_address: 32'd0};

        if (i_state.finished) begin
            // After the end token or an error every byte is dropped.
            o_state = i_state;
        end else if (over_limit) begin
            o_state.finished = 1'b1;
            o_event_valid    = 1'b1;
            o_event.kind     = EV_OVERRUN;
        end else begin
            o_state.word_shift = word_new;
            o_state.byte_index = i_state.byte_index + 2'd1;
            o_position         = pos_next;

            unique case (i_state.phase)
                PH_NAME: begin
                    // Name ends at its NUL byte, then pads to the word boundary.
                    if (i_data_byte == 8'd0) begin
                        if (word_done) begin
                            o_state.phase = PH_TOKEN;
                        end else begin
                            o_state.phase      = PH_SKIP;
                            o_state.skip_count = 32'd3 - 32'(i_state.byte_index);
                        end
                    end
                end
                PH_PLEN: begin
                    if (word_done) begin
                        o_state.size_latch = word_new;
                        o_state.phase      = PH_POFF;
                    end
                end
                PH_POFF: begin
                    // Name offset complete: report the property, skip its payload.
                    if (word_done) begin
                        o_event_valid        = 1'b1;
                        o_event.kind         = EV_PROP;
                        o_event.item_offset  = offset_next;
                        o_event.prop_size    = i_state.size_latch;
                        o_event.name_address = prop_addr;
                        if (padded == 32'd0) begin
                            o_state.phase = PH_TOKEN;
                        end else begin
                            o_state.phase      = PH_SKIP;
                            o_state.skip_count = padded;
                        end
                    end
                end
                PH_SKIP: begin
                    o_state.skip_count = i_state.skip_count - 32'd1;
                    if (i_state.skip_count == 32'd1) begin
                        o_state.phase = PH_TOKEN;
                    end
                end
                default: begin
                    // Token phase; unused phase codes behave the same.
                    o_state.phase = PH_TOKEN;
                    if (word_done) begin
                        o_event_valid = 1'b1;
                        case (word_new)
                            TOK_BEGIN_NODE: begin
                                o_event.kind        = EV_BEGIN;
                                o_event.item_offset = offset_next;
                                o_state.phase       = PH_NAME;
                            end
                            TOK_END_NODE: o_event.kind = EV_ENDNODE;
                            TOK_NOP:      o_event.kind = EV_NOP;
                            TOK_PROP: begin
                                o_event_valid = 1'b0;
                                o_state.phase = PH_PLEN;
                            end
                            TOK_END: begin
                                o_event.kind     = EV_END;
                                o_state.finished = 1'b1;
                            end
                            default: begin
                                o_event.kind     = EV_BAD;
                                o_state.finished = 1'b1;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/fdt_struct_token_parser_top.sv
// Top level of the flattened device tree structure-block parser.
// Depends on fdtp_pkg, fdtp_byte_if, fdtp_event_if and fdtp_step.
//
//   Channel    Direction  Contents
//   i_byte     in         data_byte, one structure-block byte per request
//   o_event    out        event_kind, item_offset, prop_size, name_address
//   i_cfg_*    in         write port: 0 size_limit, 1 strings_base
//
// One byte is taken every clock unless a held result stalls input; each byte
// is handled by the step logic and at most one event lands in the output register.
// A new byte is accepted while the output register is empty or being drained,
// so a stalled result stalls input only as long as it is held.
// Synchronous active-low reset returns the walker to the token phase at offset 0.
`default_nettype none

module fdt_struct_token_parser_top #(
    parameter int OFFSET_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire [31:0]  i_cfg_wdata,
    fdtp_byte_if.sink   i_byte,
    fdtp_event_if.source o_event
);
    import fdtp_pkg::*;

    t_walk_state            r_state;
    t_walk_state            n_state;
    logic [OFFSET_BITS-1:0] r_position;
    logic [OFFSET_BITS-1:0] n_position;
    logic [31:0]            r_size_limit;
    logic [31:0]            r_strings_base;
    logic                   r_out_valid;
    t_event                 r_out;
    logic                   step_event_valid;
    t_event                 step_event;
    logic                   in_fire;

    // Accept while the output register is free or being taken this cycle.
    assign i_byte.ready = !r_out_valid || o_event.ready;
    assign in_fire      = i_byte.valid && i_byte.ready;

    fdtp_step #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_step (
        .i_state        (r_state),
        .i_position     (r_position),
        .i_data_byte    (i_byte.data_byte),
        .i_size_limit   (r_size_limit),
        .i_strings_base (r_strings_base),
        .o_state        (n_state),
        .o_position     (n_position),
        .o_event_valid  (step_event_valid),
        .o_event        (step_event)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_limit   <= SIZE_LIMIT_RESET;
            r_strings_base <= STRINGS_BASE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SIZE_LIMIT:   r_size_limit   <= i_cfg_wdata;
                CFG_STRINGS_BASE: r_strings_base <= i_cfg_wdata;
                default:          r_size_limit   <= r_size_limit;
            endcase
        end
    end

    // Walker state, updated on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= '{phase: PH_TOKEN, word_shift: 32'd0, byte_index: 2'd0,
                            skip_count: 32'd0, size_latch: 32'd0, finished: 1'b0};
            r_position <= '0;
        end else if (in_fire) begin
            r_state    <= n_state;
            r_position <= n_position;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && step_event_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (in_fire && step_event_valid) begin
            r_out <= step_event;
        end
    end

    assign o_event.valid        = r_out_valid;
    assign o_event.event_kind   = r_out.kind;
    assign o_event.item_offset  = r_out.item_offset;
    assign o_event.prop_size    = r_out.prop_size;
    assign o_event.name_address = r_out.name_address;

endmodule

`default_nettype wire

// File: tb/fdt_struct_token_parser_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for fdt_struct_token_parser_top: streams structure-block bytes
// and checks every parser event against a cycle-free model of the structure walk.
// Depends on fdtp_pkg, fdtp_byte_if, fdtp_event_if and the parser RTL.

module fdt_struct_token_parser_top_tb;
    import fdtp_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_BYTES   = 340;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_BYTES    = 16;
    localparam int MAX_PRINTS    = 50;

    // Ways the single structure walk of the run is brought to its end.
    typedef enum int {
        FIN_END_TOKEN,
        FIN_BAD_TOKEN,
        FIN_ZERO_LIMIT,
        FIN_HUGE_PROP
    } t_finish;

    // One row of the directed stimulus table.
    typedef struct {
        logic [7:0] data;
        bit         typed;
        t_event     ev;
    } t_row;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;

    fdtp_byte_if  byte_ch ();
    fdtp_event_if ev_ch ();

    fdt_struct_token_parser_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_byte      (byte_ch),
        .o_event     (ev_ch)
    );

    // Walk state and register copies used for prediction.
    t_phase      walk_phase;
    logic [31:0] word_acc;
    logic [1:0]  byte_slot;
    logic [31:0] byte_pos;
    logic [31:0] skip_left;
    logic [31:0] latched_len;
    bit          walk_done;
    logic [31:0] limit_reg;
    logic [31:0] strings_reg;

    t_event      expected_events[$];
    t_row        directed_rows[$];
    logic [7:0]  record_bytes[$];

    int          fail_count;
    int          cycle_count;
    int          recv_idle_pct;
    int          hold_asks;
    int          hold_taken;
    int          hold_left;
    bit          typed_on;
    t_event      typed_event;

    // Clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTS) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
    endtask

    function automatic void start_skip(input logic [31:0] count);
        if (count == 32'd0) begin
            walk_phase = PH_TOKEN;
        end else begin
            skip_left  = count;
            walk_phase = PH_SKIP;
        end
    endfunction

    // Advances the walk by one byte and returns the event it causes, if any.
    function automatic void walk_byte(input logic [7:0] b, output bit emit, output t_event ev);
        logic [31:0] nxt;
        logic [32:0] padded;
        bit          word_done;
        emit = 1'b0;
        ev   = '0;
        nxt  = byte_pos + 32'd1;
        if (walk_done) return;
        if (byte_pos >= limit_reg) begin
            walk_done = 1'b1;
            emit      = 1'b1;
            ev.kind   = EV_OVERRUN;
            return;
        end
        word_acc  = {word_acc[23:0], b};
        word_done = (byte_slot == 2'd3);
        case (walk_phase)
            PH_NAME: begin
                // The name ends at its NUL byte; the rest of the word is padding.
                if (b == 8'h00) begin
                    if (word_done) walk_phase = PH_TOKEN;
                    else start_skip(32'd3 - byte_slot);
                end
            end
            PH_PLEN: begin
                if (word_done) begin
                    latched_len = word_acc;
                    walk_phase  = PH_POFF;
                end
            end
            PH_POFF: begin
                if (word_done) begin
                    padded          = ({1'b0, latched_len} + 33'd3) & ~33'd3;
                    emit            = 1'b1;
                    ev.kind         = EV_PROP;
                    ev.item_offset  = nxt;
                    ev.prop_size    = latched_len;
                    ev.name_address = strings_reg + word_acc;
                    start_skip(padded[32] ? 32'hFFFF_FFFF : padded[31:0]);
                end
            end
            PH_SKIP: begin
                skip_left = skip_left - 32'd1;
                if (skip_left == 32'd0) walk_phase = PH_TOKEN;
            end
            default: begin
                if (word_done) begin
                    emit       = 1'b1;
                    walk_phase = PH_TOKEN;
                    case (word_acc)
                        TOK_BEGIN_NODE: begin
                            ev.kind        = EV_BEGIN;
                            ev.item_offset = nxt;
                            walk_phase     = PH_NAME;
                        end
                        TOK_END_NODE: ev.kind = EV_ENDNODE;
                        TOK_NOP:      ev.kind = EV_NOP;
                        TOK_PROP: begin
                            emit       = 1'b0;
                            walk_phase = PH_PLEN;
                        end
                        TOK_END: begin
                            ev.kind   = EV_END;
                            walk_done = 1'b1;
                        end
                        default: begin
                            ev.kind   = EV_BAD;
                            walk_done = 1'b1;
                        end
                    endcase
                end
            end
        endcase
        byte_slot = byte_slot + 2'd1;
        byte_pos  = nxt;
    endfunction

    // Checks events leaving the block and predicts events for accepted requests.
    always @(posedge clk) begin : monitor_blk
        t_event want;
        t_event predicted;
        bit     emit;
        if (rst_n) begin
            if (ev_ch.valid && ev_ch.ready) begin
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected event kind %0d", ev_ch.event_kind));
                end else begin
                    want = expected_events.pop_front();
                    if (ev_ch.event_kind !== want.kind)
                        report_mismatch($sformatf("event_kind %0d, expected %0d",
                                                  ev_ch.event_kind, want.kind));
                    if (ev_ch.item_offset !== want.item_offset)
                        report_mismatch($sformatf("item_offset %h, expected %h",
                                                  ev_ch.item_offset, want.item_offset));
                    if (ev_ch.prop_size !== want.prop_size)
                        report_mismatch($sformatf("prop_size %h, expected %h",
                                                  ev_ch.prop_size, want.prop_size));
                    if (ev_ch.name_address !== want.name_address)
                        report_mismatch($sformatf("name_address %h, expected %h",
                                                  ev_ch.name_address, want.name_address));
                end
            end
            if (byte_ch.valid && byte_ch.ready) begin
                walk_byte(byte_ch.data_byte, emit, predicted);
                // Table rows with a typed expectation take it in place of the prediction.
                if (typed_on) begin
                    emit      = 1'b1;
                    predicted = typed_event;
                end
                if (emit) expected_events.push_back(predicted);
            end
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge clk) begin
        if (hold_taken != hold_asks) begin
            hold_taken  <= hold_asks;
            hold_left   <= HOLD_CYCLES;
            ev_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            ev_ch.ready <= 1'b0;
        end else begin
            ev_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Run watchdog.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** fdt_struct_token_parser_top: FAILED **");
            $finish;
        end
    end

    task automatic push_word(input logic [31:0] w);
        record_bytes.push_back(w[31:24]);
        record_bytes.push_back(w[23:16]);
        record_bytes.push_back(w[15:8]);
        record_bytes.push_back(w[7:0]);
    endtask

    task automatic table_word(input logic [31:0] w);
        t_row row;
        row.typed = 1'b0;
        row.ev    = '0;
        for (int i = 3; i >= 0; i--) begin
            row.data = w[i*8 +: 8];
            directed_rows.push_back(row);
        end
    endtask

    // Marks the last table row as causing the given event.
    task automatic table_expect(input t_event_kind kind, input logic [31:0] offset,
                                input logic [31:0] size, input logic [31:0] addr);
        t_row row;
        row                 = directed_rows.pop_back();
        row.typed           = 1'b1;
        row.ev.kind         = kind;
        row.ev.item_offset  = offset;
        row.ev.prop_size    = size;
        row.ev.name_address = addr;
        directed_rows.push_back(row);
    endtask

    // Offers one request with random idle cycles ahead; called and returns at a falling edge.
    task automatic send_byte(input logic [7:0] b, input bit typed, input t_event ev,
                             input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        typed_on          <= typed;
        typed_event       <= ev;
        do @(posedge clk); while (!byte_ch.ready);
        @(negedge clk);
    endtask

    task automatic configure(input logic [31:0] limit, input logic [31:0] base);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SIZE_LIMIT;
        cfg_wdata <= limit;
        @(negedge clk);
        cfg_index <= CFG_STRINGS_BASE;
        cfg_wdata <= base;
        @(negedge clk);
        cfg_we      <= 1'b0;
        limit_reg   = limit;
        strings_reg = base;
    endtask

    // Stops the request side and waits until every predicted event has left the block or the drain limit runs out.
    task automatic wait_idle(input int settle);
        int waited;
        waited = 0;
        byte_ch.valid <= 1'b0;
        while (expected_events.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (settle) @(negedge clk);
    endtask

    // Stimulus.
    initial begin : stimulus_blk
        int          send_idle_pct;
        int          sent;
        int          pick;
        int          name_len;
        int          plen;
        logic [31:0] bad_word;
        t_finish     fin;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_SIZE_LIMIT;
        cfg_wdata         = '0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        ev_ch.ready       = 1'b0;
        typed_on          = 1'b0;
        typed_event       = '0;
        recv_idle_pct     = 0;
        hold_asks         = 0;
        hold_taken        = 0;
        hold_left         = 0;
        fail_count        = 0;
        cycle_count       = 0;
        walk_phase        = PH_TOKEN;
        word_acc          = '0;
        byte_slot         = '0;
        byte_pos          = '0;
        skip_left         = '0;
        latched_len       = '0;
        walk_done         = 1'b0;
        limit_reg         = SIZE_LIMIT_RESET;
        strings_reg       = STRINGS_BASE_RESET;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: NOP, a node with an empty name, an empty property whose
        // name address wraps, and a node end, all at the widest register values.
        table_word(TOK_NOP);
        table_expect(EV_NOP, 32'd0, 32'd0, 32'd0);
        table_word(TOK_BEGIN_NODE);
        table_expect(EV_BEGIN, 32'd8, 32'd0, 32'd0);
        table_word(32'h00FF_FFFF);
        table_word(TOK_PROP);
        table_word(32'h0000_0000);
        table_word(32'hFFFF_FFFF);
        table_expect(EV_PROP, 32'd24, 32'd0, 32'hFFFF_FFFE);
        table_word(TOK_END_NODE);
        table_expect(EV_ENDNODE, 32'd0, 32'd0, 32'd0);

        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].ev, 0);

        // Random part: well-formed records with random names, lengths and payloads.
        for (int p = 0; p < 3; p++) begin
            wait_idle(SETTLE_CYCLES);
            case (p)
                0: begin
                    send_idle_pct = 24;
                    recv_idle_pct <= 55;
                    configure(byte_pos + 32'd20000 + $urandom_range(0, 32'h00FF_FFFF), $urandom);
                end
                1: begin
                    send_idle_pct = 55;
                    recv_idle_pct <= 24;
                    configure(32'hFFFF_FFFF, 32'h0000_0000);
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                    configure(byte_pos + 32'd3000 + $urandom_range(0, 255), $urandom);
                    // Hold the result side off so the block fills and stalls requests.
                    hold_asks <= hold_asks + 1;
                end
            endcase
            sent = 0;
            while (sent < PHASE_BYTES) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    push_word(TOK_BEGIN_NODE);
                    name_len = $urandom_range(0, 14);
                    repeat (name_len) record_bytes.push_back(8'($urandom_range(1, 255)));
                    record_bytes.push_back(8'h00);
                    repeat ((4 - (name_len + 1) % 4) % 4) record_bytes.push_back(8'($urandom));
                end else if (pick < 50) begin
                    push_word(TOK_END_NODE);
                end else if (pick < 60) begin
                    push_word(TOK_NOP);
                end else begin
                    if ($urandom_range(0, 9) == 0) plen = $urandom_range(25, 200);
                    else plen = $urandom_range(0, 24);
                    push_word(TOK_PROP);
                    push_word(plen);
                    push_word($urandom);
                    repeat ((plen + 3) & ~3) record_bytes.push_back(8'($urandom));
                end
                sent += record_bytes.size();
                while (record_bytes.size() != 0)
                    send_byte(record_bytes.pop_front(), 1'b0, '0, send_idle_pct);
            end
        end

        // The walk stops for good after its first terminal event, so each run
        // ends it in one of the possible ways and then shows later bytes ignored.
        wait_idle(SETTLE_CYCLES);
        fin = t_finish'($urandom_range(0, 3));
        case (fin)
            FIN_END_TOKEN: push_word(TOK_END);
            FIN_BAD_TOKEN: begin
                do bad_word = $urandom;
                while (bad_word == TOK_BEGIN_NODE || bad_word == TOK_END_NODE ||
                       bad_word == TOK_PROP || bad_word == TOK_NOP || bad_word == TOK_END);
                push_word(bad_word);
            end
            FIN_ZERO_LIMIT: configure(32'd0, strings_reg);
            default: begin
                // Largest payload length: the skip runs into the byte limit.
                configure(byte_pos + 32'd12 + $urandom_range(0, 16), $urandom);
                push_word(TOK_PROP);
                push_word(32'hFFFF_FFFF);
                push_word($urandom);
                repeat (36) record_bytes.push_back(8'($urandom));
            end
        endcase
        repeat (TAIL_BYTES) record_bytes.push_back(8'($urandom));
        while (record_bytes.size() != 0)
            send_byte(record_bytes.pop_front(), 1'b0, '0, 10);

        wait_idle(10);
        if (expected_events.size() != 0)
            report_mismatch($sformatf("%0d events never arrived", expected_events.size()));
        if (fail_count == 0) begin
            $display("** fdt_struct_token_parser_top: PASSED **");
        end else begin
            $display("** fdt_struct_token_parser_top: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/fdtp_pkg.sv
rtl/fdtp_byte_if.sv
rtl/fdtp_event_if.sv
rtl/fdtp_step.sv
rtl/fdt_struct_token_parser_top.sv
tb/fdt_struct_token_parser_top_tb.sv
